// ===== design/ppal_pkg.sv =====
// Package for the position PD controller with acceleration norm limit.
// Holds widths, register indexes, the acceleration limit and shared types; no dependencies.
package ppal_pkg;
	localparam int unsigned AddrW = 5;
	localparam logic [19:0] AccelLimit = 20'd589824;
	localparam int unsigned SqrtSteps = 32;

	typedef enum logic [2:0] {
		REG_TARGET_X = 3'd0,
		REG_TARGET_Y = 3'd1,
		REG_TARGET_Z = 3'd2,
		REG_GAIN_POS = 3'd3,
		REG_GAIN_VXY = 3'd4,
		REG_GAIN_VZ  = 3'd5,
		REG_MASS     = 3'd6,
		REG_GRAVITY  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic [23:0] gain_position;
		logic [23:0] gain_velocity_xy;
		logic [23:0] gain_velocity_z;
		logic [23:0] vehicle_mass;
		logic [23:0] gravity_accel;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Round to nearest with ties toward plus infinity, then divide by 2^16.
	function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t >>> 16;
	endfunction
endpackage

// ===== design/ppal_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ppal_pkg.
module ppal_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ppal_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output ppal_pkg::cfg_t cfg
);
	import ppal_pkg::*;
	cfg_t cfg_q;
	reg_idx_t idx;
	assign idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x <= 32'sd0;
			cfg_q.target_y <= 32'sd0;
			cfg_q.target_z <= 32'sd327680;
			cfg_q.gain_position <= 24'd131072;
			cfg_q.gain_velocity_xy <= 24'd96338;
			cfg_q.gain_velocity_z <= 24'd292946;
			cfg_q.vehicle_mass <= 24'd268698;
			cfg_q.gravity_accel <= 24'd642908;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_TARGET_X: cfg_q.target_x <= pwdata;
				REG_TARGET_Y: cfg_q.target_y <= pwdata;
				REG_TARGET_Z: cfg_q.target_z <= pwdata;
				REG_GAIN_POS: cfg_q.gain_position <= pwdata[23:0];
				REG_GAIN_VXY: cfg_q.gain_velocity_xy <= pwdata[23:0];
				REG_GAIN_VZ:  cfg_q.gain_velocity_z <= pwdata[23:0];
				REG_MASS:     cfg_q.vehicle_mass <= pwdata[23:0];
				REG_GRAVITY:  cfg_q.gravity_accel <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TARGET_X: prdata = cfg_q.target_x;
			REG_TARGET_Y: prdata = cfg_q.target_y;
			REG_TARGET_Z: prdata = cfg_q.target_z;
			REG_GAIN_POS: prdata = {8'd0, cfg_q.gain_position};
			REG_GAIN_VXY: prdata = {8'd0, cfg_q.gain_velocity_xy};
			REG_GAIN_VZ:  prdata = {8'd0, cfg_q.gain_velocity_z};
			REG_MASS:     prdata = {8'd0, cfg_q.vehicle_mass};
			REG_GRAVITY:  prdata = {8'd0, cfg_q.gravity_accel};
			default:      prdata = 32'd0;
		endcase
	end
endmodule

// ===== design/ppal_sqrt_stage.sv =====
// One restoring square-root step per pipeline stage.
// Depends on ppal_pkg; used in a chain inside the top level.
module ppal_sqrt_stage (
	input  logic [63:0] rem_in,
	input  logic [31:0] root_in,
	input  logic [5:0] step,
	output logic [63:0] rem_out,
	output logic [31:0] root_out
);
	import ppal_pkg::*;
	logic [65:0] trial;
	logic [65:0] cur;
	always_comb begin
		cur = {2'b0, rem_in} >> {step, 1'b0};
		trial = {32'd0, root_in, 2'b01};
		if (cur[33:0] >= trial[33:0] && cur[65:34] == 32'd0 || cur[65:34] != 32'd0) begin
			rem_out = rem_in - (64'(trial[33:0]) << {step, 1'b0});
			root_out = {root_in[30:0], 1'b1};
		end else begin
			rem_out = rem_in;
			root_out = {root_in[30:0], 1'b0};
		end
	end
endmodule

// ===== design/position_pd_accel_limit_unit.sv =====
// Accepts one item per cycle while the output is not stalled.
// The pipeline holds the 32-step square root and three 21-bit divider chains,
// one step per stage, plus product, sum and force stages.
// All stages advance together when the output is free; valid bits reset to zero,
// configuration resets to the listed defaults.
module position_pd_accel_limit_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ppal_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [20:0] accel_x,
	output logic signed [20:0] accel_y,
	output logic signed [20:0] accel_z,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic norm_limited
);
	import ppal_pkg::*;
	localparam int unsigned DivSteps = 21;
	localparam int unsigned NS = SqrtSteps + DivSteps;

	cfg_t cfg;
	ppal_cfg_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Stage 1: errors and products.
	logic v_s1;
	logic signed [57:0] pp_s1 [3];
	logic signed [57:0] pv_s1 [3];
	// Stage 2: raw acceleration.
	logic v_s2;
	logic signed [31:0] a_s2 [3];
	// Stage 3: squares.
	logic v_s3;
	logic signed [31:0] a_s3 [3];
	logic [63:0] sq_s3 [3];
	// Stage 4: sum and limit test.
	logic v_s4;
	logic signed [31:0] a_s4 [3];
	logic [65:0] sum_s4;
	logic lim_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s1[0] <= 58'(($signed({pos_x[31], pos_x}) - $signed({cfg.target_x[31],
				cfg.target_x})) * $signed({1'b0, cfg.gain_position}));
			pp_s1[1] <= 58'(($signed({pos_y[31], pos_y}) - $signed({cfg.target_y[31],
				cfg.target_y})) * $signed({1'b0, cfg.gain_position}));
			pp_s1[2] <= 58'(($signed({pos_z[31], pos_z}) - $signed({cfg.target_z[31],
				cfg.target_z})) * $signed({1'b0, cfg.gain_position}));
			pv_s1[0] <= 58'(vel_x * $signed({1'b0, cfg.gain_velocity_xy}));
			pv_s1[1] <= 58'(vel_y * $signed({1'b0, cfg.gain_velocity_xy}));
			pv_s1[2] <= 58'(vel_z * $signed({1'b0, cfg.gain_velocity_z}));
			for (int i = 0; i < 3; i++) begin
				a_s2[i] <= sat32(round_q16(-(64'(pp_s1[i]) + 64'(pv_s1[i]))));
				a_s3[i] <= a_s2[i];
				sq_s3[i] <= 64'(a_s2[i] * a_s2[i]);
				a_s4[i] <= a_s3[i];
			end
			sum_s4 <= 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
			lim_s4 <= (66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2])) >
				66'(AccelLimit) * 66'(AccelLimit);
		end
	end

	// Square root chain. The sum is at most 3*2^62, so 64 bits hold it;
	// unlimited items pass with their raw values untouched.
	logic [63:0] rem_p [NS+1];
	logic [31:0] root_p [NS+1];
	logic signed [31:0] a_p [NS+1][3];
	logic lim_p [NS+1];
	logic v_p [NS+1];
	logic [52:0] drem_p [NS+1][3];
	logic [20:0] q_p [NS+1][3];

	always_comb begin
		rem_p[0] = sum_s4[63:0];
		root_p[0] = 32'd0;
		lim_p[0] = lim_s4;
		v_p[0] = v_s4;
		for (int i = 0; i < 3; i++) begin
			a_p[0][i] = a_s4[i];
			drem_p[0][i] = 53'd0;
			q_p[0][i] = 21'd0;
		end
	end

	logic [63:0] rem_n [SqrtSteps];
	logic [31:0] root_n [SqrtSteps];
	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		ppal_sqrt_stage u_st (.rem_in(rem_p[k]), .root_in(root_p[k]),
			.step(6'(SqrtSteps - 1 - k)), .rem_out(rem_n[k]), .root_out(root_n[k]));
	end

	// Register storage for the chain.
	logic [63:0] rem_r [NS];
	logic [31:0] root_r [NS];
	logic signed [31:0] a_r [NS][3];
	logic lim_r [NS];
	logic v_r [NS];
	logic [52:0] drem_r [NS][3];
	logic [20:0] q_r [NS][3];

	for (genvar k = 0; k < NS; k++) begin : g_chain
		always_comb begin
			rem_p[k+1] = rem_r[k];
			root_p[k+1] = root_r[k];
			lim_p[k+1] = lim_r[k];
			v_p[k+1] = v_r[k];
			for (int i = 0; i < 3; i++) begin
				a_p[k+1][i] = a_r[k][i];
				drem_p[k+1][i] = drem_r[k][i];
				q_p[k+1][i] = q_r[k][i];
			end
		end
		if (k < SqrtSteps) begin : g_root
			always_ff @(posedge clk) begin
				if (adv) begin
					a_r[k] <= a_p[k];
					lim_r[k] <= lim_p[k];
					rem_r[k] <= rem_n[k];
					root_r[k] <= root_n[k];
					for (int i = 0; i < 3; i++) begin
						// Dividend |a|*L + n/2 is set up once the root is final.
						drem_r[k][i] <= 53'd0;
						q_r[k][i] <= 21'd0;
					end
				end
			end
		end else begin : g_div
			always_ff @(posedge clk) begin
				if (adv) begin
					a_r[k] <= a_p[k];
					lim_r[k] <= lim_p[k];
					root_r[k] <= root_p[k];
					rem_r[k] <= rem_p[k];
					for (int i = 0; i < 3; i++) begin
						logic [52:0] num;
						logic [52:0] cur;
						logic [31:0] mag;
						mag = a_p[k][i][31] ? 32'(-a_p[k][i]) : a_p[k][i];
						num = 53'(mag) * 53'(AccelLimit) + 53'(root_p[k] >> 1);
						cur = (k == SqrtSteps) ? (num >> (DivSteps - 1)) :
							{drem_p[k][i][51:0], num[DivSteps - 1 - (k - SqrtSteps)]};
						if (cur >= 53'(root_p[k]) && root_p[k] != 32'd0) begin
							drem_r[k][i] <= cur - 53'(root_p[k]);
							q_r[k][i] <= {q_p[k][i][19:0], 1'b1};
						end else begin
							drem_r[k][i] <= cur;
							q_r[k][i] <= {q_p[k][i][19:0], 1'b0};
						end
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r[k] <= 1'b0;
			else if (adv) v_r[k] <= v_p[k];
		end
	end

	// Final acceleration select, then force products and output register.
	logic v_s5;
	logic signed [20:0] acc_s5 [3];
	logic lim_s5;
	logic signed [47:0] fm_s6 [3];
	logic signed [48:0] mg_s6;
	logic signed [20:0] acc_s6 [3];
	logic lim_s6;
	logic v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			lim_s5 <= lim_p[NS];
			for (int i = 0; i < 3; i++) begin
				if (lim_p[NS])
					acc_s5[i] <= a_p[NS][i][31] ? -$signed(q_p[NS][i]) : $signed(q_p[NS][i]);
				else
					acc_s5[i] <= a_p[NS][i][20:0];
				fm_s6[i] <= 48'(acc_s5[i] * $signed({1'b0, cfg.vehicle_mass}));
				acc_s6[i] <= acc_s5[i];
			end
			mg_s6 <= $signed({1'b0, 48'(cfg.vehicle_mass * cfg.gravity_accel)});
			lim_s6 <= lim_s5;
			accel_x <= acc_s6[0];
			accel_y <= acc_s6[1];
			accel_z <= acc_s6[2];
			force_x <= sat32(round_q16(64'(fm_s6[0])));
			force_y <= sat32(round_q16(64'(fm_s6[1])));
			force_z <= sat32(round_q16(64'(fm_s6[2]) + 64'(mg_s6)));
			norm_limited <= lim_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_p[NS]; v_s6 <= v_s5; out_valid <= v_s6;
		end
	end
endmodule

// ===== design/ppal_checker.sv =====
// Port-level checks for the position PD controller.
// Depends on ppal_pkg; bound to position_pd_accel_limit_unit.
module ppal_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_stall,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [20:0] accel_x,
	input  logic signed [20:0] accel_y,
	input  logic signed [20:0] accel_z,
	input  logic norm_limited
);
	import ppal_pkg::*;
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall)) else $error("input stalled without cause");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accel_x) && $stable(norm_limited))
		else $error("result changed under stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && norm_limited |-> accel_x <= 21'sd589824 && accel_x >= -21'sd589824 &&
		accel_y <= 21'sd589824 && accel_z <= 21'sd589824) else $error("limit exceeded");
endmodule

bind position_pd_accel_limit_unit ppal_checker u_chk (.clk, .arst_n, .in_stall,
	.out_valid, .out_stall, .accel_x, .accel_y, .accel_z, .norm_limited);
